FILE: hdl/distinct_level_ranker_defines.svh
// assertion macros
`ifndef DISTINCT_LEVEL_RANKER_DEFINES_SVH
`define DISTINCT_LEVEL_RANKER_DEFINES_SVH
`define DLR_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("%m failed");
`define DLR_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("%m failed");
`endif

FILE: hdl/dlr_pkg.sv
`timescale 1ns / 1ps
package dlr_pkg;
  localparam int KEY_W = 40;
  localparam int CNT_W = 10;
  localparam int DEG_W = 15;
  localparam logic signed [KEY_W-1:0] SENTINEL = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic [DEG_W-1:0] DEG_CAP = '1;
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [0:0] REG_GRID = 1'b0;
  localparam logic [0:0] REG_MODE = 1'b1;
  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_TIE, ST_EMIT, ST_HOLD
  } state_t;
  typedef struct packed {
    logic [1:0] command;
    logic signed [KEY_W-1:0] energy_key;
    logic [7:0] row_tag;
    logic [7:0] col_tag;
    logic [4:0] level_index;
  } in_item_t;
  typedef struct packed {
    logic signed [KEY_W-1:0] level_key;
    logic [CNT_W-1:0] tie_count;
    logic [DEG_W-1:0] weighted_degeneracy;
    logic [7:0] tie_row;
    logic [7:0] tie_col;
    logic empty_level;
    logic last_of_level;
    logic store_overflow;
    logic ties_truncated;
  } out_item_t;
endpackage

FILE: hdl/dlr_in_if.sv
`timescale 1ns / 1ps
interface dlr_in_if;
  import dlr_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/dlr_out_if.sv
`timescale 1ns / 1ps
interface dlr_out_if;
  import dlr_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/dlr_weight.sv
`timescale 1ns / 1ps
module dlr_weight #(
  parameter int TAG_BITS = 8
) (
  input  logic [TAG_BITS-1:0] s,
  input  logic [TAG_BITS-1:0] t,
  input  logic [7:0]          g,
  input  logic                mode,
  output logic [9:0]          w
);
  import dlr_pkg::*;
  logic [8:0] sx, tx, h, f;
  logic s_end, t_end, s_mid, t_mid;
  always_comb begin
    sx = 9'(s);
    tx = 9'(t);
    f = {1'b0, g};
    h = {2'b0, g[7:1]};
    s_end = (sx == h) || (sx == f);
    t_end = (tx == h) || (tx == f);
    s_mid = (h < sx) && (sx < f);
    t_mid = (h < tx) && (tx < f);
    if (!mode) begin
      if (s_end && t_end) w = 10'd1;
      else if ((s_end && t_mid) || (t_end && s_mid)) w = 10'd2;
      else if (s_mid && t_mid) w = 10'd4;
      else w = 10'd1000;
    end else begin
      if ((tx == f && sx == f) || (tx == h && sx == h)) w = 10'd1;
      else if (sx == h && tx == f) w = 10'd2;
      else if ((sx == h && t_mid) || (tx == f && s_mid) ||
               (tx != f && tx != h && sx == tx)) w = 10'd4;
      else w = 10'd8;
    end
  end
endmodule

FILE: hdl/distinct_level_ranker.sv
`timescale 1ns / 1ps
// append and clear: handled in idle, in_ch.ready stays high
// read of level i (capped at MAX_LEVELS-1): accept, i+1 scan passes and one tie
// pass over the store (N records, one store read port), then each listed tied
// item is emitted, held while out_ch.ready is low; one item in flight at a time
// reset (rst_n low, synchronous): store empty, flags clear, grid_r 6, mode 0
module distinct_level_ranker #(
  parameter int MAX_RECORDS = 512,
  parameter int MAX_TIES = 32,
  parameter int MAX_LEVELS = 32,
  parameter int TAG_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  dlr_in_if.sink      in_ch,
  dlr_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dlr_pkg::*;
`include "distinct_level_ranker_defines.svh"
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int TW = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
  localparam int TCW = $clog2(MAX_TIES + 1);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int EW = KEY_W + 2 * TAG_BITS;

  logic [7:0] grid_r;
  logic mode_r;
  logic [EW-1:0] mem [MAX_RECORDS];
  logic [EW-1:0] rd_q;
  logic [TAG_BITS*2-1:0] ties [MAX_TIES];
  logic [CW-1:0] count_r;
  logic ovf_r;
  state_t st_r, st_nxt;
  logic [CW-1:0] ptr_r;
  logic rdv_r;
  logic [LW-1:0] lv_r, tgt_r;
  logic signed [KEY_W-1:0] prev_r, cur_r;
  logic [CNT_W-1:0] tc_r;
  logic [TCW-1:0] listed_r, ei_r;
  logic [DEG_W-1:0] deg_r;
  out_item_t o_r;
  logic ov_r;
  logic acc, wr;
  logic signed [KEY_W-1:0] k;
  logic [TAG_BITS-1:0] ks, kt;
  logic [9:0] w;
  logic [DEG_W:0] dsum;
  logic [TAG_BITS*2-1:0] te;
  logic [4:0] li;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      REG_GRID: cfg_prdata = {24'b0, grid_r};
      REG_MODE: cfg_prdata = {31'b0, mode_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = (st_r == ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data = o_r;
  assign k = rd_q[EW-1 -: KEY_W];
  assign ks = rd_q[2*TAG_BITS-1 -: TAG_BITS];
  assign kt = rd_q[TAG_BITS-1:0];
  assign dsum = {1'b0, deg_r} + (DEG_W+1)'(w);
  assign li = in_ch.data.level_index;

  dlr_weight #(.TAG_BITS(TAG_BITS)) u_w (
    .s(ks), .t(kt), .g(grid_r), .mode(mode_r), .w(w));

  always_ff @(posedge clk) begin
    if (acc && in_ch.data.command == CMD_APPEND && count_r < CW'(MAX_RECORDS))
      mem[count_r[AW-1:0]] <= {in_ch.data.energy_key,
        in_ch.data.row_tag[TAG_BITS-1:0], in_ch.data.col_tag[TAG_BITS-1:0]};
    rd_q <= mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_TIE && rdv_r && k == cur_r && listed_r < TCW'(MAX_TIES))
      ties[listed_r[TW-1:0]] <= {ks, kt};
  end
  assign te = ties[ei_r[TW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc && in_ch.data.command == CMD_READ) st_nxt = ST_SCAN;
      ST_SCAN: if (ptr_r == count_r && lv_r == tgt_r) st_nxt = ST_TIE;
      ST_TIE: if (ptr_r == count_r) st_nxt = ST_EMIT;
      ST_EMIT: if (!ov_r || out_ch.ready) st_nxt = ST_HOLD;
      ST_HOLD: begin
        if (out_ch.ready) st_nxt = (o_r.last_of_level) ? ST_IDLE : ST_EMIT;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= 8'd6;
      mode_r <= 1'b0;
      count_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
      ptr_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      if (wr && cfg_paddr[2] == REG_GRID) grid_r <= cfg_pwdata[7:0];
      if (wr && cfg_paddr[2] == REG_MODE) mode_r <= cfg_pwdata[0];
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          ptr_r <= '0;
          rdv_r <= 1'b0;
          lv_r <= '0;
          cur_r <= SENTINEL;
          prev_r <= SENTINEL;
          tc_r <= '0;
          listed_r <= '0;
          deg_r <= '0;
          ei_r <= '0;
          tgt_r <= (32'(li) >= MAX_LEVELS) ? LW'(MAX_LEVELS - 1) : LW'(li);
          if (acc) begin
            if (in_ch.data.command == CMD_APPEND) begin
              if (count_r < CW'(MAX_RECORDS)) count_r <= count_r + 1'b1;
              else ovf_r <= 1'b1;
            end else if (in_ch.data.command == CMD_CLEAR) begin
              count_r <= '0;
              ovf_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (rdv_r && (lv_r == '0 || k > prev_r) && k < cur_r) cur_r <= k;
          if (ptr_r == count_r) begin
            ptr_r <= '0;
            rdv_r <= 1'b0;
            if (lv_r != tgt_r) begin
              lv_r <= lv_r + 1'b1;
              prev_r <= (rdv_r && (lv_r == '0 || k > prev_r) && k < cur_r) ? k : cur_r;
              cur_r <= SENTINEL;
            end else if (rdv_r && (lv_r == '0 || k > prev_r) && k < cur_r) begin
              cur_r <= k;
            end
          end else begin
            ptr_r <= ptr_r + 1'b1;
            rdv_r <= 1'b1;
          end
        end
        ST_TIE: begin
          if (rdv_r && k == cur_r) begin
            tc_r <= tc_r + 1'b1;
            if (listed_r < TCW'(MAX_TIES)) begin
              listed_r <= listed_r + 1'b1;
              deg_r <= dsum[DEG_W] ? DEG_CAP : dsum[DEG_W-1:0];
            end
          end
          if (ptr_r != count_r) begin
            ptr_r <= ptr_r + 1'b1;
            rdv_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (!ov_r || out_ch.ready) begin
            ov_r <= 1'b1;
            o_r.level_key <= cur_r;
            o_r.tie_count <= tc_r;
            o_r.weighted_degeneracy <= deg_r;
            o_r.tie_row <= (listed_r != '0) ? 8'(te[2*TAG_BITS-1 -: TAG_BITS]) : 8'd0;
            o_r.tie_col <= (listed_r != '0) ? 8'(te[TAG_BITS-1:0]) : 8'd0;
            o_r.empty_level <= (tc_r == '0);
            o_r.last_of_level <= (listed_r == '0) || (ei_r + 1'b1 == listed_r);
            o_r.store_overflow <= ovf_r;
            o_r.ties_truncated <= (tc_r > CNT_W'(MAX_TIES));
            ei_r <= ei_r + 1'b1;
          end
        end
        ST_HOLD: ;
        default: ;
      endcase
    end
  end

  `DLR_ASSERT_IMP(a_busy_not_ready, clk, rst_n, st_r != ST_IDLE, !in_ch.ready)
  `DLR_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(MAX_RECORDS))
  `DLR_ASSERT_NXT(a_out_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(o_r))
endmodule
